// ===== sv/sms_pkg.sv =====
`timescale 1ns / 1ps
// sms_pkg: shared widths, codes, sequencer states and control structs
// for the sorted matrix search block; no dependencies

package sms_pkg;

	// fixed field widths
	localparam int DATA_W    = 32;
	localparam int ROW_IDX_W = 6;
	localparam int COL_IDX_W = 6;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;

	// default store geometry
	localparam int DEF_MAX_ROWS    = 64;
	localparam int DEF_MAX_COLUMNS = 64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS_IN_USE = 1'b1;

	// command codes
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	// reset value of both size registers
	localparam logic [CFG_W-1:0] CFG_RESET = 7'd1;

	// search sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_RPROBE,
		S_RCMP,
		S_CPROBE,
		S_CCMP,
		S_FINISH
	} state_t;

	// sequencer to bisection unit
	typedef struct packed {
		logic load;   // lo = 0, hi = bound
		logic step;   // narrow the interval by the last compare
	} probe_ctl_t;

	// bisection unit to sequencer
	typedef struct packed {
		logic open;   // interval not empty
		logic hit;    // probed element equals target
		logic less;   // probed element below target
	} probe_stat_t;

endpackage

// ===== sv/sms_probe_unit.sv =====
`timescale 1ns / 1ps
// sms_probe_unit: shared bisection unit, half-open bounds, midpoint and
// the signed 32-bit compare used by both search phases; uses sms_pkg

module sms_probe_unit #(
	parameter int IW = 7
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sms_pkg::probe_ctl_t          ctl,
	input  logic [IW-1:0]                bound,
	input  logic signed [sms_pkg::DATA_W-1:0] rd_data,
	input  logic signed [sms_pkg::DATA_W-1:0] target,
	output sms_pkg::probe_stat_t         stat,
	output logic [IW-1:0]                mid,
	output logic [IW-1:0]                lo
);
	import sms_pkg::*;

	logic [IW-1:0] lo_q;
	logic [IW-1:0] hi_q;
	logic [IW:0]   sum_w;

	// midpoint of the inclusive range [lo, hi-1], rounded down
	assign sum_w = {1'b0, lo_q} + {1'b0, hi_q} - (IW+1)'(1);
	assign mid   = sum_w[IW:1];
	assign lo    = lo_q;

	// compare of the probed element against the target
	assign stat.open = (lo_q < hi_q);
	assign stat.hit  = (rd_data == target);
	assign stat.less = (rd_data < target);

	// bounds update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= '0;
			hi_q <= '0;
		end else if (ctl.load) begin
			lo_q <= '0;
			hi_q <= bound;
		end else if (ctl.step) begin
			if (stat.less) begin
				lo_q <= mid + IW'(1);
			end else begin
				hi_q <= mid;
			end
		end
	end

	// bounds stay ordered
	a_bounds_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		lo_q <= hi_q)
		else $error("bisection bounds crossed");

	// a step always shrinks a non-empty interval
	a_step_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step && !ctl.load && stat.open |=> (hi_q - lo_q) < $past(hi_q - lo_q))
		else $error("bisection step did not shrink the interval");

	// load never comes together with a step
	a_ctl_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.load && ctl.step))
		else $error("bisection load and step at once");

endmodule

// ===== sv/sorted_matrix_search_top.sv =====
`timescale 1ns / 1ps
// sorted_matrix_search_top: matrix store, search sequencer, config registers
// and output register; uses sms_pkg and sms_probe_unit
//
// channel  direction  handshake               payload
// in       sink       in_valid / in_stall     command, row_index, column_index, data_value
// out      source     out_valid / out_stall   found
// cfg      sink       cfg_we                  cfg_index, cfg_data
//
// a write returns no transfer on out
// a search runs a row bisection on the first column, then a column bisection on
//   the chosen row: each probe is one read of the store plus one compare
// in_stall is low only while the sequencer is idle
// a finished result sits in the output register, so the next item is taken
//   while out is stalled; a second result waits in the last state until free
// reset clears control and size registers; the store has no reset

module sorted_matrix_search_top #(
	parameter int MAX_ROWS    = sms_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLUMNS = sms_pkg::DEF_MAX_COLUMNS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input items
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  command,
	input  logic [sms_pkg::ROW_IDX_W-1:0]         row_index,
	input  logic [sms_pkg::COL_IDX_W-1:0]         column_index,
	input  logic signed [sms_pkg::DATA_W-1:0]     data_value,
	// results
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  found,
	// configuration
	input  logic                                  cfg_we,
	input  logic [sms_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [sms_pkg::CFG_W-1:0]             cfg_data
);
	import sms_pkg::*;

	localparam int MAX_DIM = (MAX_ROWS > MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS;
	localparam int IW      = $clog2(MAX_DIM + 1);
	localparam int DEPTH   = MAX_ROWS * MAX_COLUMNS;
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	state_t state_q, state_d;

	logic [CFG_W-1:0]         rows_q;
	logic [CFG_W-1:0]         cols_q;
	logic [IW-1:0]            rows_eff;
	logic [IW-1:0]            cols_eff;
	logic signed [DATA_W-1:0] target_q;
	logic [IW-1:0]            row_q;
	logic                     res_q;
	logic                     out_valid_q;
	logic                     found_q;

	logic                     in_xfer;
	logic                     out_xfer;
	logic                     mem_we;
	logic [AW-1:0]            wr_addr;
	logic                     rd_en;
	logic [IW-1:0]            rd_row;
	logic [IW-1:0]            rd_col;
	logic [AW-1:0]            rd_addr;
	logic signed [DATA_W-1:0] rd_data_q;

	probe_ctl_t               pctl;
	probe_stat_t              pstat;
	logic [IW-1:0]            pbound;
	logic [IW-1:0]            pmid;
	logic [IW-1:0]            plo;

	logic                     row_load;
	logic                     res_load;
	logic                     res_val;
	logic                     out_load;

	logic signed [DATA_W-1:0] mem [DEPTH];

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign found     = found_q;

	// size registers clamped to the store geometry
	assign rows_eff = (32'(rows_q) > MAX_ROWS) ? IW'(MAX_ROWS) : IW'(rows_q);
	assign cols_eff = (32'(cols_q) > MAX_COLUMNS) ? IW'(MAX_COLUMNS) : IW'(cols_q);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CFG_RESET;
			cols_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS_IN_USE:    rows_q <= cfg_data;
				REG_COLUMNS_IN_USE: cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// element write, dropped outside the store
	assign mem_we  = in_xfer && (command == CMD_WRITE) &&
	                 (32'(row_index) < MAX_ROWS) && (32'(column_index) < MAX_COLUMNS);
	assign wr_addr = AW'(32'(row_index) * MAX_COLUMNS + 32'(column_index));

	// probe address: first column in the row phase, chosen row in the column phase
	assign rd_row  = (state_q == S_RPROBE) ? pmid : row_q;
	assign rd_col  = (state_q == S_RPROBE) ? '0 : pmid;
	assign rd_addr = AW'(32'(rd_row) * MAX_COLUMNS + 32'(rd_col));

	// matrix store, one write and one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= data_value;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	sms_probe_unit #(
		.IW (IW)
	) u_probe (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (pctl),
		.bound   (pbound),
		.rd_data (rd_data_q),
		.target  (target_q),
		.stat    (pstat),
		.mid     (pmid),
		.lo      (plo)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control
	always_comb begin
		state_d   = state_q;
		pctl.load = 1'b0;
		pctl.step = 1'b0;
		pbound    = rows_eff;
		rd_en     = 1'b0;
		row_load  = 1'b0;
		res_load  = 1'b0;
		res_val   = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_xfer && command == CMD_SEARCH) begin
					state_d = S_START;
				end
			end
			S_START: begin
				if (rows_eff == '0 || cols_eff == '0) begin
					res_load = 1'b1;
					state_d  = S_FINISH;
				end else begin
					pctl.load = 1'b1;
					state_d   = S_RPROBE;
				end
			end
			S_RPROBE: begin
				if (pstat.open) begin
					rd_en   = 1'b1;
					state_d = S_RCMP;
				end else if (plo == '0) begin
					// target below the first element
					res_load = 1'b1;
					state_d  = S_FINISH;
				end else begin
					row_load  = 1'b1;
					pbound    = cols_eff;
					pctl.load = 1'b1;
					state_d   = S_CPROBE;
				end
			end
			S_RCMP: begin
				if (pstat.hit) begin
					res_load = 1'b1;
					res_val  = 1'b1;
					state_d  = S_FINISH;
				end else begin
					pctl.step = 1'b1;
					state_d   = S_RPROBE;
				end
			end
			S_CPROBE: begin
				if (pstat.open) begin
					rd_en   = 1'b1;
					state_d = S_CCMP;
				end else begin
					res_load = 1'b1;
					state_d  = S_FINISH;
				end
			end
			S_CCMP: begin
				if (pstat.hit) begin
					res_load = 1'b1;
					res_val  = 1'b1;
					state_d  = S_FINISH;
				end else begin
					pctl.step = 1'b1;
					state_d   = S_CPROBE;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// search payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			target_q <= data_value;
		end
		if (row_load) begin
			row_q <= plo - IW'(1);
		end
		if (res_load) begin
			res_q <= res_val;
		end
		if (out_load) begin
			found_q <= res_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	// a search transfer starts the sequencer next cycle
	a_search_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && command == CMD_SEARCH |=> state_q == S_START)
		else $error("search transfer did not start the sequencer");

	// a result appears only out of the finish state
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FINISH))
		else $error("result without finished search");

	// the chosen row lies within the rows in use
	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CPROBE || state_q == S_CCMP) |-> row_q < rows_eff)
		else $error("column phase on a row out of range");

	// a pending result is never overwritten before its transfer
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid_q || !out_stall)
		else $error("result register overwritten while stalled");

endmodule

// ===== verif/tb_sorted_matrix_search_top.sv =====
`timescale 1ns / 1ps
// tb_sorted_matrix_search_top: self-checking bench for the sorted matrix search block
// predicts each search answer from its own copy of the store and size registers;
// depends on sms_pkg and sorted_matrix_search_top

module tb_sorted_matrix_search_top;
	import sms_pkg::*;

	localparam int STORE_ROWS    = DEF_MAX_ROWS;
	localparam int STORE_COLS    = DEF_MAX_COLUMNS;
	localparam int SEARCH_CYCLES = 28;
	localparam int RANDOM_ITEMS  = 1000;
	localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	typedef enum int {RX_FREE, RX_RANDOM, RX_HEAVY, RX_PATTERN} rx_style_t;

	typedef struct {
		logic                      found;
		int                        serial;
		logic signed [DATA_W-1:0]  target;
	} answer_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic                          command;
	logic [ROW_IDX_W-1:0]          row_index;
	logic [COL_IDX_W-1:0]          column_index;
	logic signed [DATA_W-1:0]      data_value;
	logic                          out_valid;
	logic                          out_stall;
	logic                          found;
	logic                          cfg_we;
	logic [CFG_IDX_W-1:0]          cfg_index;
	logic [CFG_W-1:0]              cfg_data;

	// predicted block state
	logic signed [DATA_W-1:0]      cells [STORE_ROWS][STORE_COLS];
	bit                            written [STORE_ROWS][STORE_COLS];
	logic [CFG_W-1:0]              rows_cfg = CFG_RESET;
	logic [CFG_W-1:0]              cols_cfg = CFG_RESET;

	answer_t                       pending_answers[$];
	int                            mismatch_count = 0;
	int                            items_sent = 0;
	int                            searches_sent = 0;

	// traffic shaping
	bit                            gaps_on = 1'b0;
	int                            burst_left = 0;
	rx_style_t                     rx_style = RX_FREE;
	int                            hold_len = 0;

	sorted_matrix_search_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.row_index    (row_index),
		.column_index (column_index),
		.data_value   (data_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found        (found),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#(64'd5_000_000);
		$display("== FAIL ==");
		$finish;
	end

	// size register value as the block uses it
	function automatic int in_use(input logic [CFG_W-1:0] reg_val, input int limit);
		return (int'(reg_val) > limit) ? limit : int'(reg_val);
	endfunction

	// two-stage bisection: first column picks the row, then the row itself;
	// clean drops to 0 when a probe lands on a never-written element
	function automatic logic lookup_target(input logic signed [DATA_W-1:0] target,
			output bit clean);
		int nr, nc, lo, hi, mid, row;
		clean = 1'b1;
		nr = in_use(rows_cfg, STORE_ROWS);
		nc = in_use(cols_cfg, STORE_COLS);
		if (nr == 0 || nc == 0)
			return 1'b0;
		lo = 0;
		hi = nr - 1;
		while (hi >= lo) begin
			mid = (lo + hi) / 2;
			if (!written[mid][0])
				clean = 1'b0;
			if (cells[mid][0] == target)
				return 1'b1;
			if (cells[mid][0] < target)
				lo = mid + 1;
			else
				hi = mid - 1;
		end
		row = lo - 1;
		if (row < 0)
			return 1'b0;
		lo = 0;
		hi = nc - 1;
		while (hi >= lo) begin
			mid = (lo + hi) / 2;
			if (!written[row][mid])
				clean = 1'b0;
			if (cells[row][mid] == target)
				return 1'b1;
			if (cells[row][mid] < target)
				lo = mid + 1;
			else
				hi = mid - 1;
		end
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 40)
			$display("mismatch: %s", msg);
		mismatch_count++;
	endtask

	// one input transfer, with burst gaps; predictor follows on acceptance
	task automatic send_item(input logic cmd, input logic [ROW_IDX_W-1:0] r,
			input logic [COL_IDX_W-1:0] c, input logic signed [DATA_W-1:0] v);
		bit taken;
		bit clean;
		answer_t entry;
		if (gaps_on) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				in_valid <= 1'b0;
				if ($urandom_range(0, 7) == 0)
					repeat ($urandom_range(20, 40)) @(posedge clk);
				else
					repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left--;
		end
		in_valid     <= 1'b1;
		command      <= cmd;
		row_index    <= r;
		column_index <= c;
		data_value   <= v;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		if (cmd == CMD_WRITE) begin
			cells[r][c] = v;
			written[r][c] = 1'b1;
		end else begin
			entry.found  = lookup_target(v, clean);
			entry.serial = searches_sent;
			entry.target = v;
			searches_sent++;
			pending_answers.push_back(entry);
		end
		items_sent++;
	endtask

	// search only where every probe reads a written element
	task automatic search_for(input logic signed [DATA_W-1:0] target);
		bit clean;
		logic unused;
		unused = lookup_target(target, clean);
		if (!clean)
			return;
		send_item(CMD_SEARCH, ROW_IDX_W'($urandom_range(0, 63)),
			COL_IDX_W'($urandom_range(0, 63)), target);
	endtask

	// sender waits for every outstanding answer
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_answers.size() != 0);
	endtask

	// block fully idle: answers drained, then a further wait on the clock
	task automatic settle();
		drain_results();
		repeat (SEARCH_CYCLES + 12) @(posedge clk);
	endtask

	task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_ROWS_IN_USE)
			rows_cfg = val;
		else
			cols_cfg = val;
	endtask

	task automatic set_traffic(input bit gaps, input rx_style_t style);
		@(negedge clk);
		gaps_on    = gaps;
		burst_left = 0;
		rx_style   = style;
		@(posedge clk);
	endtask

	task automatic hold_receiver(input int cycles);
		@(negedge clk);
		hold_len = cycles;
		@(posedge clk);
	endtask

	// receiver stall pattern, long holds counted here
	initial begin
		int hold_left;
		int pat;
		logic [10:0] stall_mask;
		hold_left  = 0;
		pat        = 0;
		stall_mask = 11'b10011000101;
		out_stall  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				hold_left = hold_len;
				hold_len  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (rx_style)
					RX_FREE:    out_stall <= 1'b0;
					RX_RANDOM:  out_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY:   out_stall <= ($urandom_range(0, 3) != 0);
					default: begin
						out_stall <= stall_mask[pat];
						pat = (pat + 1) % 11;
					end
				endcase
			end
		end
	end

	// result transfer happens at the next rising edge; inputs are stable until then
	always @(negedge clk) begin
		answer_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_answers.size() == 0) begin
				report_mismatch($sformatf("result found=%b with no search outstanding", found));
			end else begin
				want = pending_answers.pop_front();
				if (found !== want.found)
					report_mismatch($sformatf("search %0d target %0d: found=%b, want %b",
						want.serial, want.target, found, want.found));
			end
		end else if (arst_n && $isunknown(out_valid)) begin
			report_mismatch("out_valid unknown");
		end
	end

	// ascending fill of the rows and columns in use, duplicates now and then
	task automatic fill_sorted(input int nr, input int nc);
		longint cur;
		longint max_step;
		int r, c;
		cur = -64'sd2147483648 + longint'($urandom_range(0, 32'h7FFF_FFFF));
		max_step = 64'sd2147483647 / longint'(nr * nc + 1);
		for (r = 0; r < nr; r++) begin
			for (c = 0; c < nc; c++) begin
				send_item(CMD_WRITE, ROW_IDX_W'(r), COL_IDX_W'(c), cur[DATA_W-1:0]);
				if ($urandom_range(0, 7) != 0)
					cur += longint'($urandom_range(1, int'(max_step)));
			end
		end
	endtask

	task automatic fill_noise(input int nr, input int nc);
		int r, c;
		for (r = 0; r < nr; r++)
			for (c = 0; c < nc; c++)
				send_item(CMD_WRITE, ROW_IDX_W'(r), COL_IDX_W'(c), $urandom);
	endtask

	// target drawn from the region in use, its neighbors or anywhere
	function automatic logic signed [DATA_W-1:0] pick_target();
		int nr, nc, r, c;
		logic signed [DATA_W-1:0] v;
		nr = in_use(rows_cfg, STORE_ROWS);
		nc = in_use(cols_cfg, STORE_COLS);
		if (nr == 0 || nc == 0)
			return $urandom;
		r = $urandom_range(0, nr - 1);
		c = $urandom_range(0, nc - 1);
		v = cells[r][c];
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return v;
			4:          return v + 1;
			5:          return v - 1;
			6:          return cells[r][0];
			7:          return $urandom;
			8:          return VALUE_MIN;
			default:    return VALUE_MAX;
		endcase
	endfunction

	// evenly spread ascending grid over the whole store
	function automatic logic signed [DATA_W-1:0] grid_value(input int r, input int c,
			input int jitter);
		longint v;
		v = -64'sd2147483648 + longint'(r * STORE_COLS + c) * 64'sd1048000 + longint'(jitter);
		return v[DATA_W-1:0];
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_grid_target(input int full_rows[4],
			input int jitter);
		logic signed [DATA_W-1:0] base;
		base = grid_value(full_rows[$urandom_range(0, 3)], $urandom_range(0, STORE_COLS - 1),
			jitter);
		case ($urandom_range(0, 9))
			6:       return base + 1;
			7:       return base - 1;
			8:       return grid_value($urandom_range(0, STORE_ROWS - 1), 0, jitter);
			9:       return $urandom;
			default: return base;
		endcase
	endfunction

	// reset sizes of one by one, extremes of the value range
	task automatic test_reset_sizes();
		set_traffic(1'b1, RX_RANDOM);
		send_item(CMD_WRITE, '0, '0, VALUE_MIN);
		search_for(VALUE_MIN);
		search_for(VALUE_MAX);
		send_item(CMD_WRITE, '0, '0, 32'sd5);
		search_for(32'sd4);
		search_for(32'sd5);
	endtask

	// three by four matrix with both value extremes and a duplicate
	task automatic test_small_matrix();
		logic signed [DATA_W-1:0] grid [3][4];
		int r, c;
		grid = '{'{VALUE_MIN, -32'sd1000, -32'sd10, 32'sd0},
			'{32'sd5, 32'sd17, 32'sd17, 32'sd300},
			'{32'sd1000, 32'sd65536, 32'sd1073741824, VALUE_MAX}};
		settle();
		write_size(REG_ROWS_IN_USE, 7'd3);
		write_size(REG_COLUMNS_IN_USE, 7'd4);
		set_traffic(1'b0, RX_PATTERN);
		for (r = 0; r < 3; r++)
			for (c = 0; c < 4; c++)
				send_item(CMD_WRITE, ROW_IDX_W'(r), COL_IDX_W'(c), grid[r][c]);
		search_for(VALUE_MAX);
		search_for(32'sd5);
		search_for(32'sd65536);
		search_for(32'sd18);
		search_for(32'sd4);
	endtask

	// zero rows or zero columns in use: nothing read, never found
	task automatic test_zero_sizes();
		settle();
		write_size(REG_ROWS_IN_USE, 7'd0);
		search_for(VALUE_MIN);
		search_for(32'sd5);
		settle();
		write_size(REG_ROWS_IN_USE, 7'd3);
		write_size(REG_COLUMNS_IN_USE, 7'd0);
		search_for(32'sd5);
	endtask

	// whole store geometry, sizes above the maximum, long receiver hold
	task automatic test_full_geometry();
		int full_rows[4];
		int jitter, r, c, i;
		settle();
		write_size(REG_ROWS_IN_USE, 7'd127);
		write_size(REG_COLUMNS_IN_USE, 7'd64);
		set_traffic(1'b1, RX_RANDOM);
		jitter = $urandom_range(0, 1000);
		full_rows[0] = 0;
		full_rows[1] = STORE_ROWS - 1;
		full_rows[2] = $urandom_range(1, 31);
		full_rows[3] = $urandom_range(32, 62);
		for (r = 0; r < STORE_ROWS; r++)
			send_item(CMD_WRITE, ROW_IDX_W'(r), '0, grid_value(r, 0, jitter));
		for (i = 0; i < 4; i++)
			for (c = 1; c < STORE_COLS; c++)
				send_item(CMD_WRITE, ROW_IDX_W'(full_rows[i]), COL_IDX_W'(c),
					grid_value(full_rows[i], c, jitter));
		repeat (60) search_for(pick_grid_target(full_rows, jitter));
		// receiver holds off while searches keep coming, input side must back up
		set_traffic(1'b0, RX_FREE);
		hold_receiver(400);
		repeat (8) search_for(pick_grid_target(full_rows, jitter));
		settle();
		write_size(REG_ROWS_IN_USE, 7'd64);
		write_size(REG_COLUMNS_IN_USE, 7'd127);
		set_traffic(1'b1, RX_PATTERN);
		repeat (30) search_for(pick_grid_target(full_rows, jitter));
		settle();
		write_size(REG_ROWS_IN_USE, 7'd127);
		set_traffic(1'b0, RX_HEAVY);
		repeat (20) search_for(pick_grid_target(full_rows, jitter));
	endtask

	function automatic int pick_size();
		int k;
		k = $urandom_range(0, 19);
		if (k == 0)
			return 0;
		if (k < 9)
			return $urandom_range(1, 4);
		if (k < 17)
			return $urandom_range(5, 8);
		return $urandom_range(9, 16);
	endfunction

	// load a matrix, then search it; mostly sorted, some noise, some corrupted
	task automatic test_random_phases();
		int goal, kind, nr, nc;
		goal = items_sent + RANDOM_ITEMS;
		while (items_sent < goal) begin
			settle();
			kind = $urandom_range(0, 19);
			nr = pick_size();
			nc = pick_size();
			write_size(REG_ROWS_IN_USE, CFG_W'(nr));
			write_size(REG_COLUMNS_IN_USE, CFG_W'(nc));
			set_traffic($urandom_range(0, 3) != 0, rx_style_t'($urandom_range(0, 3)));
			if (kind < 14) begin
				fill_sorted(nr, nc);
			end else if (kind < 17) begin
				fill_noise(nr, nc);
			end else begin
				fill_sorted(nr, nc);
				if (nr > 0 && nc > 0)
					repeat ($urandom_range(1, 3))
						send_item(CMD_WRITE, ROW_IDX_W'($urandom_range(0, nr - 1)),
							COL_IDX_W'($urandom_range(0, nc - 1)), $urandom);
			end
			repeat ($urandom_range(4, 24)) begin
				search_for(pick_target());
				if ($urandom_range(0, 49) == 0)
					drain_results();
			end
		end
	endtask

	// stimulus sequence
	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		command      = CMD_WRITE;
		row_index    = '0;
		column_index = '0;
		data_value   = '0;
		cfg_we       = 1'b0;
		cfg_index    = REG_ROWS_IN_USE;
		cfg_data     = CFG_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_sizes();
		test_small_matrix();
		test_zero_sizes();
		test_full_geometry();
		test_random_phases();
		settle();
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
